// ===== design/double_ended_queue_top_macros.svh =====
// Assertion helpers for the deque block.
// All checks are sampled on the rising clock edge and held off while reset is low.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Plain property
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define DEQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps
package deq_pkg;

    // Default ring size
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command transfer
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    // Result transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STAT_W-1:0]        status;
        logic                     last;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

endpackage

// ===== design/deq_ram.sv =====
`timescale 1ns / 1ps
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/deq_ring.sv =====
`timescale 1ns / 1ps
// Ring position unit: (base + offset) modulo DEPTH, both operands below DEPTH.
module deq_ring #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_base,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_offset,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_addr
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W:0] WRAP = (IDX_W + 1)'(DEPTH);

    logic [IDX_W:0] w_sum;
    logic [IDX_W:0] w_wrapped;

    // Sum stays below twice DEPTH, so one compare and subtract folds it
    always_comb begin
        w_sum     = {1'b0, i_base} + {1'b0, i_offset};
        w_wrapped = (w_sum >= WRAP) ? (w_sum - WRAP) : w_sum;
        o_addr    = w_wrapped[IDX_W-1:0];
    end

endmodule

// ===== design/double_ended_queue_top.sv =====
// Bounded double-ended queue of signed 32-bit values kept in a ring buffer of DEPTH
// entries. Each command transfer pushes at the front or back, pops the front or back
// (returning the removed value), or dumps all entries front to back; every command
// answers with result transfers whose final one has last set, and each result reports
// the occupancy after the command (low five bits). Full pushes return status full,
// pops and dumps on an empty queue return status empty, unused codes return ok.
// A command is taken only while the block is idle, and the next one is not taken until
// the last result of the current one has been transferred. Each command passes an
// address step, where pushes and refusals finish; a pop that removes an entry and each
// dumped entry then pass a read step for the single registered read port of the entry
// RAM, and every result is held in an output step; a dump repeats these steps per entry.
// The address step, and the read step of a front pop, use the one shared ring position adder.
`timescale 1ns / 1ps
`include "double_ended_queue_top_macros.svh"
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  deq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output deq_pkg::t_out_item  o_out_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] BACK_STEP = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ONE_STEP  = IDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [deq_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [deq_pkg::DATA_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]                 r_front, n_front;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic [CNT_W-1:0]                 r_iter, n_iter;
    deq_pkg::t_out_item               r_out, n_out;

    logic [IDX_W-1:0]                 w_offset;
    logic [IDX_W-1:0]                 w_addr;
    logic                             w_we;
    logic [deq_pkg::DATA_W-1:0]       w_rdata;
    logic [CNT_W-1:0]                 w_count_dec;
    logic [CNT_W-1:0]                 w_iter_inc;
    logic                             w_full;
    logic                             w_empty;

    // Shared ring position adder
    deq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_base   (r_front),
        .i_offset (w_offset),
        .o_addr   (w_addr)
    );

    // Entry storage
    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (r_value),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_count_dec = r_count - 1'b1;
    assign w_iter_inc  = r_iter + 1'b1;
    assign w_full      = (r_count == FULL_CNT);
    assign w_empty     = (r_count == '0);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_value  = r_value;
        n_front  = r_front;
        n_count  = r_count;
        n_iter   = r_iter;
        n_out    = r_out;
        w_offset = '0;
        w_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item.command;
                    n_value = i_in_item.value;
                    n_iter  = '0;
                    n_state = S_ADDR;
                end
            end

            // Decide the command; pushes, refusals and unused codes finish here
            S_ADDR: begin
                n_out.result_value = '0;
                n_out.status       = deq_pkg::ST_OK;
                n_out.last         = 1'b1;
                n_state            = S_OUT;
                case (r_cmd)
                    deq_pkg::CMD_PUSH_FRONT: begin
                        w_offset = BACK_STEP;
                        if (w_full) begin
                            n_out.status = deq_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_front = w_addr;
                            n_count = r_count + 1'b1;
                        end
                    end
                    deq_pkg::CMD_PUSH_BACK: begin
                        w_offset = r_count[IDX_W-1:0];
                        if (w_full) begin
                            n_out.status = deq_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    deq_pkg::CMD_POP_FRONT: begin
                        w_offset = '0;
                        if (w_empty) begin
                            n_out.status = deq_pkg::ST_EMPTY;
                        end else begin
                            n_count = w_count_dec;
                            n_state = S_READ;
                        end
                    end
                    deq_pkg::CMD_POP_BACK: begin
                        w_offset = w_count_dec[IDX_W-1:0];
                        if (w_empty) begin
                            n_out.status = deq_pkg::ST_EMPTY;
                        end else begin
                            n_count = w_count_dec;
                            n_state = S_READ;
                        end
                    end
                    deq_pkg::CMD_DUMP: begin
                        w_offset = r_iter[IDX_W-1:0];
                        if (w_empty) begin
                            n_out.status = deq_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    default: ;
                endcase
                n_out.occupancy = deq_pkg::OCC_W'(n_count);
            end

            // RAM data is back; pop front also advances the front here
            S_READ: begin
                n_out.result_value = w_rdata;
                n_out.status       = deq_pkg::ST_OK;
                n_out.occupancy    = deq_pkg::OCC_W'(r_count);
                n_out.last         = 1'b1;
                if (r_cmd == deq_pkg::CMD_POP_FRONT) begin
                    w_offset = ONE_STEP;
                    n_front  = w_addr;
                end
                if (r_cmd == deq_pkg::CMD_DUMP) begin
                    n_out.last = (w_iter_inc == r_count);
                end
                n_state = S_OUT;
            end

            // Hold the result until the transfer completes
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_cmd == deq_pkg::CMD_DUMP && !r_out.last) begin
                        n_iter  = w_iter_inc;
                        n_state = S_ADDR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_iter  <= n_iter;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

    `DEQ_ASSERT(a_count_bound, r_count <= FULL_CNT, "entry count above depth")
    `DEQ_ASSERT_IMPL(a_busy_while_out, o_out_valid, o_in_stall, "input open with result pending")
    `DEQ_ASSERT_IMPL(a_full_status, o_out_valid && r_out.status == deq_pkg::ST_FULL,
                     w_full, "full status while not full")
    `DEQ_ASSERT_IMPL(a_empty_status, o_out_valid && r_out.status == deq_pkg::ST_EMPTY,
                     w_empty, "empty status while not empty")
    `DEQ_ASSERT_NEXT(a_last_frees, o_out_valid && !i_out_stall && r_out.last,
                     !o_in_stall, "not idle after last transfer")

endmodule
